// File: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the serial-bus frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int FRAME_BYTES  = 25;
    localparam int LOST_BYTE    = 23;
    localparam int MAX_CHANNELS = 16;
    localparam int CH_BITS      = 4;
    localparam int RAW_BITS     = 11;
    localparam int PAYLOAD_BITS = MAX_CHANNELS * RAW_BITS;
    localparam int PAYLOAD_BYTES = PAYLOAD_BITS / 8;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int PROD_BITS    = RAW_BITS + 32;

    localparam logic [7:0]  HEADER_BYTE   = 8'h0F;
    localparam logic [7:0]  END_BYTE      = 8'h00;
    localparam logic [7:0]  LOST_BITS     = 8'h0C;
    localparam logic [10:0] RAW_LOW       = 11'd172;
    localparam logic [10:0] PWM_LOW       = 11'd1000;
    localparam logic [10:0] PWM_HIGH      = 11'd2000;
    localparam logic [10:0] PWM_SPAN      = 11'd1000;
    // ceil(2^32 / 1639) * 1000: exact floor(y*1000/1639) for 11-bit y
    localparam logic [31:0] PWM_SCALE     = 32'd2620481000;
    localparam logic [15:0] TIMEOUT_RESET = 16'd300;
    localparam logic [4:0]  CH_COUNT_RESET = 5'd10;

    typedef enum logic [1:0] {
        ACT_BYTE     = 2'd0,
        ACT_TICK     = 2'd1,
        ACT_LINE_ERR = 2'd2
    } action_t;

    typedef enum logic {
        CFG_TIMEOUT  = 1'b0,
        CFG_CH_COUNT = 1'b1
    } cfg_index_t;

    typedef enum logic {
        KIND_CHANNEL = 1'b0,
        KIND_TIMEOUT = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                     kind;
        logic                      lost;
        logic [CH_BITS-1:0]        last_ch;
        logic [PAYLOAD_BITS-1:0]   payload;
    } job_t;

endpackage

// File: rtl/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front
// Framing, lost flag, tick counter and configuration; issues decode jobs.
// ----------------------------------------------------------------------------
module sfr_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [1:0]          action,
    input  logic [7:0]          rx_byte,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [15:0]         cfg_wdata,
    output logic                push,
    output sfr_pkg::job_t       job
);
    import sfr_pkg::*;

    logic [7:0]  frame_store_reg [FRAME_BYTES-1];
    logic [4:0]  pos_reg, pos_next;
    logic        lost_reg, lost_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] timeout_reg;
    logic [4:0]  ch_count_reg;
    logic        store_we;
    logic [15:0] elapsed_inc;
    logic [4:0]  ch_sat;
    logic [PAYLOAD_BITS-1:0] payload;

    always_comb begin
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            payload[8*i +: 8] = frame_store_reg[i+1];
        end
    end

    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign ch_sat = (ch_count_reg > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : ch_count_reg;

    always_comb begin
        pos_next     = pos_reg;
        lost_next    = lost_reg;
        elapsed_next = elapsed_reg;
        store_we     = 1'b0;
        push         = 1'b0;
        job.kind     = KIND_CHANNEL;
        job.lost     = lost_reg;
        job.last_ch  = CH_BITS'(ch_sat - 5'd1);
        job.payload  = payload;
        if (accept) begin
            unique case (action_t'(action))
                ACT_BYTE: begin
                    if (pos_reg == 5'd0 && rx_byte != HEADER_BYTE) begin
                        pos_next = 5'd0;
                    end else if (pos_reg == 5'(FRAME_BYTES - 1)) begin
                        pos_next = 5'd0;
                        if (rx_byte == END_BYTE) begin
                            lost_next    = (frame_store_reg[LOST_BYTE] & LOST_BITS) != 8'd0;
                            elapsed_next = 16'd0;
                            job.lost     = lost_next;
                            push         = (ch_sat != 5'd0);
                        end
                    end else begin
                        store_we = 1'b1;
                        pos_next = pos_reg + 5'd1;
                    end
                end
                ACT_TICK: begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc > timeout_reg && !lost_reg) begin
                        lost_next   = 1'b1;
                        push        = 1'b1;
                        job.kind    = KIND_TIMEOUT;
                        job.lost    = 1'b1;
                        job.last_ch = '0;
                        job.payload = '0;
                    end
                end
                ACT_LINE_ERR: begin
                    pos_next  = 5'd0;
                    lost_next = 1'b1;
                end
                default: begin
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            frame_store_reg[pos_reg] <= rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= 5'd0;
            lost_reg     <= 1'b1;
            elapsed_reg  <= 16'd0;
            timeout_reg  <= TIMEOUT_RESET;
            ch_count_reg <= CH_COUNT_RESET;
        end else begin
            pos_reg     <= pos_next;
            lost_reg    <= lost_next;
            elapsed_reg <= elapsed_next;
            if (cfg_we) begin
                unique case (cfg_index_t'(cfg_addr))
                    CFG_TIMEOUT:  timeout_reg  <= cfg_wdata;
                    CFG_CH_COUNT: ch_count_reg <= cfg_wdata[4:0];
                endcase
            end
        end
    end

endmodule

// File: rtl/sfr_queue.sv
// ----------------------------------------------------------------------------
// sfr_queue
// Small job FIFO between the framing front end and the decode back end.
// ----------------------------------------------------------------------------
module sfr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  sfr_pkg::job_t  push_job,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output sfr_pkg::job_t  head_job
);
    import sfr_pkg::*;

    job_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign full       = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// File: rtl/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back
// Walks jobs one channel per cycle unless stalled; scales raw to pwm, drives output.
// ----------------------------------------------------------------------------
module sfr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  sfr_pkg::job_t       q_job,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);
    import sfr_pkg::*;

    // channel walker
    logic                    act_valid_reg, act_valid_next;
    kind_t                   act_kind_reg;
    logic                    act_lost_reg;
    logic [CH_BITS-1:0]      act_ch_reg, act_last_ch_reg;
    logic [PAYLOAD_BITS-1:0] act_payload_reg;
    // scale stage
    logic                    s1_valid_reg;
    kind_t                   s1_kind_reg;
    logic                    s1_lost_reg, s1_last_reg, s1_low_reg;
    logic [CH_BITS-1:0]      s1_ch_reg;
    logic [PROD_BITS-1:0]    s1_prod_reg, s1_prod_next;
    // output stage
    logic                    m_valid_reg;
    logic [15:0]             m_data_reg;
    logic                    m_user_reg, m_last_reg;

    logic                    en, act_last;
    logic [RAW_BITS-1:0]     raw, raw_off, quot, pwm_next;

    assign en       = !m_valid_reg || m_tready;
    assign act_last = (act_ch_reg == act_last_ch_reg);
    assign pop      = q_valid && en && (!act_valid_reg || act_last);
    assign act_valid_next = pop || (act_valid_reg && !act_last);

    assign raw          = act_payload_reg[RAW_BITS-1:0];
    assign raw_off      = raw - RAW_LOW;
    assign s1_prod_next = {32'd0, raw_off} * {{RAW_BITS{1'b0}}, PWM_SCALE};

    assign quot = s1_prod_reg[PROD_BITS-1:32];
    always_comb begin
        if (s1_low_reg) begin
            pwm_next = PWM_LOW;
        end else if (quot > PWM_SPAN) begin
            pwm_next = PWM_HIGH;
        end else begin
            pwm_next = quot + PWM_LOW;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (pop) begin
                act_kind_reg    <= q_job.kind;
                act_lost_reg    <= q_job.lost;
                act_last_ch_reg <= q_job.last_ch;
                act_ch_reg      <= '0;
                act_payload_reg <= q_job.payload;
            end else if (act_valid_reg) begin
                act_ch_reg      <= act_ch_reg + 1'b1;
                act_payload_reg <= act_payload_reg >> RAW_BITS;
            end
            s1_kind_reg <= act_kind_reg;
            s1_ch_reg   <= act_ch_reg;
            s1_lost_reg <= act_lost_reg;
            s1_last_reg <= act_last;
            s1_low_reg  <= (act_kind_reg == KIND_TIMEOUT) || (raw <= RAW_LOW);
            s1_prod_reg <= s1_prod_next;
            m_data_reg  <= {s1_lost_reg, pwm_next, s1_ch_reg};
            m_user_reg  <= s1_kind_reg;
            m_last_reg  <= s1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else if (en) begin
            act_valid_reg <= act_valid_next;
            s1_valid_reg  <= act_valid_reg;
            m_valid_reg   <= s1_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: rtl/sbus_frame_receiver.sv
// ----------------------------------------------------------------------------
// sbus_frame_receiver
// A frame's closing byte or a timeout tick pushes a job into the job queue;
// its results then pass through the channel walker, scale and output stages.
// Throughput: one input per cycle while the 4-entry job queue has room;
// results leave one per cycle unless stalled; a frame holds the decode back end.
// Reset (synchronous, active low): framing idle, signal lost, counter zero,
// timeout_ms 300, channel_count 10, queue and output empty.
// ----------------------------------------------------------------------------
module sbus_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic [1:0]  s_tuser,    // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [3:0] channel, [14:4] pwm_value, [15] signal_lost
    output logic        m_tuser,    // [0] kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import sfr_pkg::*;

    logic accept, push, pop, full, q_valid;
    job_t push_job, q_job;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    sfr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .action    (s_tuser),
        .rx_byte   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .job       (push_job)
    );

    sfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (full),
        .head_valid (q_valid),
        .head_job   (q_job)
    );

    sfr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: rtl/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks on the result stream of the frame receiver.
// ----------------------------------------------------------------------------
module sfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    import sfr_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_timeout_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_TIMEOUT |-> m_tlast)
        else $error("timeout result not last");

    a_timeout_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_TIMEOUT |->
            m_tdata[3:0] == 4'd0 && m_tdata[14:4] == PWM_LOW && m_tdata[15])
        else $error("timeout result fields wrong");

    a_pwm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[14:4] >= PWM_LOW && m_tdata[14:4] <= PWM_HIGH)
        else $error("pulse width out of range");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind sbus_frame_receiver sfr_checker u_sfr_checker (.*);

// File: bench/sfr_channel_checker.sv
// ----------------------------------------------------------------------------
// sfr_channel_checker
// Watches the request, result and register ports of the frame receiver,
// tracks framing, signal-lost and elapsed-tick state, and compares every
// result with the oldest predicted one, field by field.
// ----------------------------------------------------------------------------
module sfr_channel_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    output int          pending,
    output int          errors
);
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    localparam int          MAX_REPORTS = 40;
    localparam int unsigned RAW_SPAN    = 1639;
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    typedef struct {
        kind_t       kind;
        logic [3:0]  channel;
        logic [10:0] pwm;
        logic        lost;
        logic        last;
    } rx_result_t;

    rx_result_t  pwm_results_q[$];
    rx_result_t  oldest;
    logic [7:0]  frame_bytes [FRAME_BYTES];
    int unsigned byte_pos;
    logic        lost_flag;
    logic [15:0] elapsed_ticks;
    logic [15:0] timeout_ms;
    logic [4:0]  channel_count;

    function automatic int unsigned raw_channel(input int unsigned idx);
        int unsigned bit_off;
        int unsigned base;
        logic [23:0] window;
        bit_off = idx * RAW_BITS;
        base    = 1 + bit_off / 8;
        window  = {frame_bytes[base + 2], frame_bytes[base + 1], frame_bytes[base]};
        return (window >> (bit_off % 8)) & 24'h7FF;
    endfunction

    function automatic logic [10:0] pulse_width(input int unsigned raw);
        int unsigned width_us;
        if (raw <= RAW_LOW) begin
            return PWM_LOW;
        end
        width_us = (raw - RAW_LOW) * PWM_SPAN / RAW_SPAN + PWM_LOW;
        return (width_us > PWM_HIGH) ? PWM_HIGH : width_us[10:0];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    task automatic track_request(input logic [1:0] act, input logic [7:0] data);
        rx_result_t  r;
        int unsigned n;
        case (act)
            ACT_BYTE: begin
                if (byte_pos == 0 && data != HEADER_BYTE) begin
                    return;
                end
                frame_bytes[byte_pos] = data;
                byte_pos++;
                if (byte_pos < FRAME_BYTES) begin
                    return;
                end
                byte_pos = 0;
                if (frame_bytes[FRAME_BYTES - 1] != END_BYTE) begin
                    return;
                end
                lost_flag     = (frame_bytes[LOST_BYTE] & LOST_BITS) != 8'h00;
                elapsed_ticks = '0;
                n = (channel_count > MAX_CHANNELS) ? MAX_CHANNELS : channel_count;
                for (int i = 0; i < n; i++) begin
                    r.kind    = KIND_CHANNEL;
                    r.channel = i[3:0];
                    r.pwm     = pulse_width(raw_channel(i));
                    r.lost    = lost_flag;
                    r.last    = (i == n - 1);
                    pwm_results_q.push_back(r);
                end
            end
            ACT_TICK: begin
                if (elapsed_ticks != ELAPSED_MAX) begin
                    elapsed_ticks++;
                end
                if (elapsed_ticks > timeout_ms && !lost_flag) begin
                    lost_flag = 1'b1;
                    r.kind    = KIND_TIMEOUT;
                    r.channel = '0;
                    r.pwm     = PWM_LOW;
                    r.lost    = 1'b1;
                    r.last    = 1'b1;
                    pwm_results_q.push_back(r);
                end
            end
            ACT_LINE_ERR: begin
                byte_pos  = 0;
                lost_flag = 1'b1;
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pwm_results_q.delete();
            byte_pos      = 0;
            lost_flag     = 1'b1;
            elapsed_ticks = '0;
            timeout_ms    = TIMEOUT_RESET;
            channel_count = CH_COUNT_RESET;
            errors        = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pwm_results_q.size() == 0) begin
                    report_mismatch("unexpected result, tdata", m_tdata, 0);
                end else begin
                    oldest = pwm_results_q.pop_front();
                    if (m_tuser != oldest.kind)
                        report_mismatch("kind", m_tuser, oldest.kind);
                    if (m_tdata[3:0] != oldest.channel)
                        report_mismatch("channel", m_tdata[3:0], oldest.channel);
                    if (m_tdata[14:4] != oldest.pwm)
                        report_mismatch("pwm_value", m_tdata[14:4], oldest.pwm);
                    if (m_tdata[15] != oldest.lost)
                        report_mismatch("signal_lost", m_tdata[15], oldest.lost);
                    if (m_tlast != oldest.last)
                        report_mismatch("last", m_tlast, oldest.last);
                end
            end
            if (cfg_we) begin
                if (cfg_index_t'(cfg_addr) == CFG_TIMEOUT) begin
                    timeout_ms = cfg_wdata;
                end else begin
                    channel_count = cfg_wdata[4:0];
                end
            end
            if (s_tvalid && s_tready) begin
                track_request(s_tuser, s_tdata);
            end
        end
        pending = pwm_results_q.size();
    end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the frame receiver with directed frames, ticks and line errors,
// then random frame traffic under several register settings and idle
// patterns, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         HOLD_CYCLES    = 200;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         PHASE_REQS     = 15;
    localparam int         PHASES         = 4;

    localparam logic [10:0] EDGE_RAWS [MAX_CHANNELS] = '{
        11'd0, 11'd171, 11'd172, 11'd173, 11'd174, 11'd175, 11'd1000, 11'd1809,
        11'd1810, 11'd1811, 11'd1812, 11'd2047, 11'd1, 11'd1024, 11'd2046, 11'd1500
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic        cfg_addr;
    logic [15:0] cfg_wdata;

    int          pending;
    int          fail_count;
    int unsigned idle_pct;
    int unsigned stall_pct;
    bit          hold_req;
    int          reqs_sent;
    int          quiet_cycles;
    int unsigned pick;
    logic [7:0]  flags;
    logic [15:0] next_timeout;
    logic [4:0]  next_count;
    logic [PAYLOAD_BITS-1:0] edge_payload;

    sbus_frame_receiver uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    sfr_channel_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .pending   (pending),
        .errors    (fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("FAILED: results differ");
        $finish;
    end

    // called and returns at a falling edge
    task automatic send_req(input logic [1:0] act, input logic [7:0] data);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        reqs_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_config(input logic [15:0] timeout, input logic [4:0] count);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_TIMEOUT;
        cfg_wdata <= timeout;
        @(negedge aclk);
        cfg_addr  <= CFG_CH_COUNT;
        cfg_wdata <= {11'd0, count};
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_frame(input logic [PAYLOAD_BITS-1:0] payload,
                              input logic [7:0] lost_byte, input logic [7:0] tail);
        send_req(ACT_BYTE, HEADER_BYTE);
        for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            send_req(ACT_BYTE, payload[k*8 +: 8]);
        end
        send_req(ACT_BYTE, lost_byte);
        send_req(ACT_BYTE, tail);
    endtask

    function automatic logic [PAYLOAD_BITS-1:0] random_payload();
        logic [PAYLOAD_BITS-1:0] p;
        for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            p[k*8 +: 8] = 8'($urandom_range(255));
        end
        return p;
    endfunction

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_BYTE;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_TIMEOUT;
        cfg_wdata = '0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b0;
        reqs_sent = 0;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            edge_payload[i*RAW_BITS +: RAW_BITS] = EDGE_RAWS[i];
        end
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: ignored action, noise, bad end, cut frame
        send_req(ACT_UNUSED, HEADER_BYTE);
        send_req(ACT_BYTE, 8'hFF);
        send_req(ACT_BYTE, END_BYTE);
        send_req(ACT_TICK, 8'h00);
        send_frame(random_payload(), 8'h00, 8'h80);
        send_req(ACT_BYTE, HEADER_BYTE);
        repeat (5) send_req(ACT_BYTE, 8'h55);
        send_req(ACT_LINE_ERR, 8'h00);

        // clamp edges, all sixteen channels, immediate timeouts; the job
        // queue fills behind a stalled result side, then drains
        set_config(16'd0, 5'd31);
        hold_req = 1'b1;
        send_frame(edge_payload, 8'h00, END_BYTE);
        send_req(ACT_TICK, 8'hFF);
        repeat (2) begin
            send_frame(random_payload(), 8'h00, END_BYTE);
            send_req(ACT_TICK, 8'h00);
        end
        drain_results();

        // zero channels: a frame still clears the flag
        set_config(16'd0, 5'd0);
        send_frame(random_payload(), 8'h00, END_BYTE);
        send_req(ACT_TICK, 8'h00);
        send_req(ACT_LINE_ERR, 8'hFF);
        send_req(ACT_TICK, 8'h00);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 58;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 58;
                end
                default: begin
                    idle_pct  = 29;
                    stall_pct = 29;
                end
            endcase
            pick = $urandom_range(9);
            next_timeout = (pick == 0) ? 16'd0 :
                           (pick == 1) ? 16'hFFFF : 16'($urandom_range(1, 12));
            pick = $urandom_range(9);
            next_count = (pick == 0) ? 5'd0 :
                         (pick == 1) ? 5'd31 :
                         (pick == 2) ? 5'($urandom_range(17, 30)) :
                                       5'($urandom_range(1, 16));
            set_config(next_timeout, next_count);

            reqs_sent = 0;
            while (reqs_sent < PHASE_REQS) begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    flags = 8'($urandom_range(255));
                    if ($urandom_range(9) < 6) begin
                        flags = flags & ~LOST_BITS;
                    end
                    send_frame(random_payload(), flags,
                               ($urandom_range(9) == 0) ? 8'($urandom_range(1, 255))
                                                        : END_BYTE);
                end else if (pick < 70) begin
                    repeat ($urandom_range(1, 10))
                        send_req(ACT_TICK, 8'($urandom_range(255)));
                end else if (pick < 80) begin
                    repeat ($urandom_range(1, 4))
                        send_req(ACT_BYTE, 8'($urandom_range(255)));
                end else if (pick < 88) begin
                    send_req(ACT_BYTE, HEADER_BYTE);
                    repeat ($urandom_range(0, 23))
                        send_req(ACT_BYTE, 8'($urandom_range(255)));
                    send_req(ACT_LINE_ERR, 8'($urandom_range(255)));
                end else if (pick < 94) begin
                    send_req(ACT_LINE_ERR, 8'($urandom_range(255)));
                end else begin
                    send_req(ACT_UNUSED, 8'($urandom_range(255)));
                end
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
